/* rtl/mcc_pkg.sv */
// Shared types, constants and helpers for the Morse code codec.
// No dependencies; used by mcc_ctrl, mcc_dp and morse_code_codec_core.
package mcc_pkg;

	// Code geometry
	localparam int MAX_SYMBOLS = 6;
	localparam int LEN_W       = 3;
	localparam int PAT_W       = MAX_SYMBOLS;
	localparam int REV_IDX_W   = MAX_SYMBOLS + 1;
	localparam int REV_DEPTH   = 2 << MAX_SYMBOLS;
	localparam int FWD_DEPTH   = 256;
	localparam int FWD_IDX_W   = 8;

	// Character codes
	localparam logic [7:0] CHAR_DOT   = 8'h2A;
	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Item and register codes
	localparam logic MODE_TABLE = 1'b0;
	localparam logic MODE_DATA  = 1'b1;
	localparam logic DIR_DECODE = 1'b0;
	localparam logic DIR_ENCODE = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [7:0]       in_char;
		logic [LEN_W-1:0] code_length;
		logic [5:0]       code_pattern;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       last;
		logic       not_found;
	} out_item_t;

	// Controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic load;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic clear_done;
		logic needs_out;
		logic out_free;
		logic res_last;
	} dp_sts_t;

	// Low-bit mask of the given code length (length at most MAX_SYMBOLS)
	function automatic logic [PAT_W-1:0] len_mask(input logic [LEN_W-1:0] len);
		logic [PAT_W:0] m;
		m = ((PAT_W + 1)'(1) << len) - (PAT_W + 1)'(1);
		return m[PAT_W-1:0];
	endfunction

	// Reverse table index: leading marker bit above the pattern
	function automatic logic [REV_IDX_W-1:0] rev_index(input logic [LEN_W-1:0] len,
		input logic [PAT_W-1:0] pat);
		return (REV_IDX_W'(1) << len) | REV_IDX_W'(pat & len_mask(len));
	endfunction

endpackage

/* rtl/morse_code_codec_core.sv */
// Morse code codec with loadable code tables. A table-write item stores a
// character and its code in a forward table (by character) and a reverse
// table (by code). With direction 1 a letter becomes '*'/'-' symbols and a
// space; with direction 0 symbols collect into a pending code that the next
// other character turns into its letter. Missing entries and over-long codes
// raise not_found. After reset both tables are cleared in one pass, during
// which in_ready stays low. Items are taken one at a time: table writes and
// decode symbols give no output; every other data character first has its
// table entry read into a register, then gives its results one per load
// of the output register, so an encoded letter of n symbols gives n + 1
// results (at most 7) and a passed or decoded character one result; the
// output register holds while the output side is not ready.
// Depends on mcc_pkg, mcc_ctrl and mcc_dp.
module morse_code_codec_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mcc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mcc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	mcc_pkg::ctl_cmd_t cmd;
	mcc_pkg::dp_sts_t  sts;

	// Sequencer
	mcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Tables, pending code and output register
	mcc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* rtl/mcc_ctrl.sv */
// Controller state machine of the Morse code codec.
// Depends on mcc_pkg; drives the mcc_dp datapath through ctl_cmd_t.
module mcc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mcc_pkg::dp_sts_t  sts,
	output mcc_pkg::ctl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Handshake and commands
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.load   = (state_q == ST_EMIT) && sts.out_free;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clear_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.accept && sts.needs_out) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.load && sts.res_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/mcc_dp.sv */
// Datapath of the Morse code codec: code tables, pending code, output register.
// Depends on mcc_pkg; sequenced by mcc_ctrl.
module mcc_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mcc_pkg::ctl_cmd_t  cmd,
	output mcc_pkg::dp_sts_t   sts,
	input  mcc_pkg::in_item_t  in_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output mcc_pkg::out_item_t out_data
);

	typedef struct packed {
		logic                      vld;
		logic [mcc_pkg::LEN_W-1:0] len;
		logic [mcc_pkg::PAT_W-1:0] pat;
	} fwd_entry_t;

	typedef struct packed {
		logic       vld;
		logic [7:0] ch;
	} rev_entry_t;

	// Tables: each entry carries its valid bit, cleared by the pass after reset
	fwd_entry_t fwd_mem [mcc_pkg::FWD_DEPTH];
	rev_entry_t rev_mem [mcc_pkg::REV_DEPTH];
	logic [mcc_pkg::FWD_IDX_W-1:0] clr_q;

	// Configuration and pending code
	logic                      direction_q;
	logic [mcc_pkg::PAT_W-1:0] pend_pat_q;
	logic [mcc_pkg::LEN_W-1:0] pend_len_q;
	logic                      pend_ovf_q;

	// Per-item capture
	fwd_entry_t                fwd_rd_q;
	rev_entry_t                rev_rd_q;
	logic [7:0]                ch_q;
	logic                      pass_q;
	logic                      enc_q;
	logic                      ovf_q;
	logic [mcc_pkg::LEN_W-1:0] cnt_q;

	// Output register
	logic               out_valid_q;
	mcc_pkg::out_item_t out_q;

	logic                          is_letter;
	logic                          is_sym;
	logic                          is_data;
	logic                          wr_tbl;
	logic [mcc_pkg::LEN_W-1:0]     len_sat;
	logic [mcc_pkg::PAT_W-1:0]     pat_m;
	logic [mcc_pkg::REV_IDX_W-1:0] wr_idx;
	logic [mcc_pkg::REV_IDX_W-1:0] pend_idx;
	mcc_pkg::out_item_t            res;

	// Input decode
	always_comb begin
		is_letter = ((in_data.in_char >= 8'h41) && (in_data.in_char <= 8'h5A)) ||
			((in_data.in_char >= 8'h61) && (in_data.in_char <= 8'h7A));
		is_sym    = (in_data.in_char == mcc_pkg::CHAR_DOT) ||
			(in_data.in_char == mcc_pkg::CHAR_DASH);
		is_data   = (in_data.mode == mcc_pkg::MODE_DATA);
		wr_tbl    = cmd.accept && (in_data.mode == mcc_pkg::MODE_TABLE);
		len_sat   = (in_data.code_length > mcc_pkg::LEN_W'(mcc_pkg::MAX_SYMBOLS)) ?
			mcc_pkg::LEN_W'(mcc_pkg::MAX_SYMBOLS) : in_data.code_length;
		pat_m     = mcc_pkg::PAT_W'(in_data.code_pattern) & mcc_pkg::len_mask(len_sat);
		wr_idx    = mcc_pkg::rev_index(len_sat, pat_m);
		pend_idx  = mcc_pkg::rev_index(pend_len_q, pend_pat_q);
	end

	// Clearing pass, table write and registered table reads
	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			fwd_mem[clr_q]                             <= '0;
			rev_mem[clr_q[mcc_pkg::REV_IDX_W-1:0]]     <= '0;
		end else if (wr_tbl) begin
			fwd_mem[in_data.in_char] <= '{vld: 1'b1, len: len_sat, pat: pat_m};
			rev_mem[wr_idx]          <= '{vld: 1'b1, ch: in_data.in_char};
		end
		if (cmd.accept) begin
			fwd_rd_q <= fwd_mem[in_data.in_char];
			rev_rd_q <= rev_mem[pend_idx];
		end
	end

	// Item capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			ch_q         <= in_data.in_char;
			enc_q        <= (direction_q == mcc_pkg::DIR_ENCODE);
			ovf_q        <= pend_ovf_q;
			if (direction_q == mcc_pkg::DIR_ENCODE) begin
				pass_q <= !is_letter;
			end else begin
				pass_q <= (pend_len_q == '0) && !pend_ovf_q;
			end
		end
	end

	// Control state: clear counter, register, pending code, counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			direction_q <= mcc_pkg::DIR_ENCODE;
			pend_pat_q  <= '0;
			pend_len_q  <= '0;
			pend_ovf_q  <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				direction_q <= cfg_wdata;
			end
			// pending code only moves on decode-direction data
			if (cmd.accept && is_data && (direction_q == mcc_pkg::DIR_DECODE)) begin
				if (is_sym) begin
					if (pend_len_q >= mcc_pkg::LEN_W'(mcc_pkg::MAX_SYMBOLS)) begin
						pend_ovf_q <= 1'b1;
					end else begin
						if (in_data.in_char == mcc_pkg::CHAR_DASH) begin
							pend_pat_q[pend_len_q] <= 1'b1;
						end
						pend_len_q <= pend_len_q + 1'b1;
					end
				end else begin
					pend_pat_q <= '0;
					pend_len_q <= '0;
					pend_ovf_q <= 1'b0;
				end
			end
			if (cmd.accept) begin
				cnt_q <= '0;
			end else if (cmd.load) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result for the current emit slot
	always_comb begin
		res.out_char  = ch_q;
		res.last      = 1'b1;
		res.not_found = 1'b0;
		if (pass_q) begin
			res.out_char = ch_q;
		end else if (enc_q) begin
			if (!fwd_rd_q.vld) begin
				res.out_char  = mcc_pkg::CHAR_SPACE;
				res.not_found = 1'b1;
			end else if (cnt_q < fwd_rd_q.len) begin
				res.out_char = fwd_rd_q.pat[cnt_q] ? mcc_pkg::CHAR_DASH : mcc_pkg::CHAR_DOT;
				res.last     = 1'b0;
			end else begin
				res.out_char = mcc_pkg::CHAR_SPACE;
			end
		end else begin
			res.out_char  = rev_rd_q.vld ? rev_rd_q.ch : 8'h00;
			res.not_found = !rev_rd_q.vld || ovf_q;
		end
	end

	// Output register load
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= res;
		end
	end

	// Status back to the controller
	always_comb begin
		sts.clear_done = (clr_q == mcc_pkg::FWD_IDX_W'(mcc_pkg::FWD_DEPTH - 1));
		sts.needs_out  = is_data && !((direction_q == mcc_pkg::DIR_DECODE) && is_sym);
		sts.out_free   = !out_valid_q || out_ready;
		sts.res_last   = res.last;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* tb/morse_codec_checker.sv */
// Scoreboard for the Morse code codec: watches both channels and the direction register.
// It predicts each output character from its own copy of the code tables and pending code.
// Depends on mcc_pkg for the item types and character codes.
module morse_codec_checker
	import mcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	output int        mismatches,
	output int        chars_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow tables, pending code and direction
	logic             fwd_valid [FWD_DEPTH];
	logic [LEN_W-1:0] fwd_len   [FWD_DEPTH];
	logic [PAT_W-1:0] fwd_pat   [FWD_DEPTH];
	logic             rev_valid [REV_DEPTH];
	logic [7:0]       rev_char  [REV_DEPTH];
	logic [PAT_W-1:0] pend_pat;
	logic [LEN_W-1:0] pend_len;
	logic             pend_ovf;
	logic             dir;

	// Output characters still owed by the block, oldest first
	out_item_t out_chars_due [$];

	// Reverse slot: marker bit at position len above the masked pattern
	function automatic int code_slot(input int len, input int pat);
		int mask;
		mask = (1 << len) - 1;
		return ((1 << len) | (pat & mask)) & (REV_DEPTH - 1);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic void emit(input logic [7:0] c, input logic fin, input logic miss);
		out_item_t r;
		r.out_char  = c;
		r.last      = fin;
		r.not_found = miss;
		out_chars_due = {out_chars_due, r};
	endfunction

	// Update the shadow state for one input transfer and queue what it produces
	task automatic translate_item(input in_item_t it);
		int len;
		int pat;
		int slot;
		if (it.mode == MODE_TABLE) begin
			// over-long codes saturate, pattern bits above the length are dropped
			len = (it.code_length > MAX_SYMBOLS) ? MAX_SYMBOLS : it.code_length;
			pat = it.code_pattern & ((1 << len) - 1);
			fwd_valid[it.in_char] = 1'b1;
			fwd_len[it.in_char]   = LEN_W'(len);
			fwd_pat[it.in_char]   = PAT_W'(pat);
			slot = code_slot(len, pat);
			rev_valid[slot] = 1'b1;
			rev_char[slot]  = it.in_char;
		end else if (dir == DIR_ENCODE) begin
			if (!is_alpha(it.in_char)) begin
				emit(it.in_char, 1'b1, 1'b0);
			end else if (!fwd_valid[it.in_char]) begin
				emit(CHAR_SPACE, 1'b1, 1'b1);
			end else begin
				for (int i = 0; i < fwd_len[it.in_char]; i++)
					emit(fwd_pat[it.in_char][i] ? CHAR_DASH : CHAR_DOT, 1'b0, 1'b0);
				emit(CHAR_SPACE, 1'b1, 1'b0);
			end
		end else if (it.in_char == CHAR_DOT || it.in_char == CHAR_DASH) begin
			// symbol joins the pending code; a full code drops it and flags overflow
			if (pend_len >= MAX_SYMBOLS) begin
				pend_ovf = 1'b1;
			end else begin
				if (it.in_char == CHAR_DASH)
					pend_pat[pend_len] = 1'b1;
				pend_len = pend_len + 1'b1;
			end
		end else if (pend_len == 0 && !pend_ovf) begin
			emit(it.in_char, 1'b1, 1'b0);
		end else begin
			slot = code_slot(int'(pend_len), int'(pend_pat));
			emit(rev_valid[slot] ? rev_char[slot] : 8'h00, 1'b1, !rev_valid[slot] || pend_ovf);
			pend_pat = '0;
			pend_len = '0;
			pend_ovf = 1'b0;
		end
	endtask

	// Per-edge: reset, register write, input prediction, output compare
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			for (int k = 0; k < FWD_DEPTH; k++) begin
				fwd_valid[k] = 1'b0;
				fwd_len[k]   = '0;
				fwd_pat[k]   = '0;
			end
			for (int k = 0; k < REV_DEPTH; k++) begin
				rev_valid[k] = 1'b0;
				rev_char[k]  = '0;
			end
			pend_pat = '0;
			pend_len = '0;
			pend_ovf = 1'b0;
			dir = DIR_ENCODE;
			out_chars_due.delete();
		end else begin
			if (cfg_we)
				dir = cfg_wdata;
			if (in_valid && in_ready)
				translate_item(in_data);
			if (out_valid && out_ready) begin
				if (out_chars_due.size() == 0) begin
					$error("output transfer with nothing owed: out_char %h", out_data.out_char);
					mismatches++;
				end else begin
					want = out_chars_due.pop_front();
					if (out_data.out_char !== want.out_char) begin
						$error("out_char: expected %h, got %h", want.out_char, out_data.out_char);
						mismatches++;
					end
					if (out_data.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, out_data.last);
						mismatches++;
					end
					if (out_data.not_found !== want.not_found) begin
						$error("not_found: expected %b, got %b", want.not_found,
							out_data.not_found);
						mismatches++;
					end
				end
			end
		end
		chars_due = out_chars_due.size();
	end

endmodule

/* tb/testbench.sv */
// Top of the codec regression: clock, reset, stimulus and verdict.
// Instantiates morse_code_codec_core and morse_codec_checker; uses mcc_pkg types.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mcc_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;
	logic      cfg_we = 1'b0;
	logic      cfg_wdata = 1'b0;
	int        mismatches;
	int        chars_due;
	int        items_sent = 0;
	bit        steady = 1'b0;     // no idling on either side while set

	// Table codes loaded so far, used to build well-formed decode sequences
	int         code_len_pool [$];
	int         code_pat_pool [$];
	logic [7:0] letter_pool   [$];

	morse_code_codec_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	morse_codec_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.chars_due  (chars_due)
	);

	always #4 clk = ~clk;

	// Mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] rand_letter();
		return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_terminator();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == CHAR_DOT || c == CHAR_DASH);
		return c;
	endfunction

	// One input transfer; called and returns at a falling edge
	task automatic send_item(input in_item_t it);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Data character; the unused code fields carry random bits
	task automatic send_char(input logic [7:0] c);
		in_item_t it;
		it.mode         = MODE_DATA;
		it.in_char      = c;
		it.code_length  = LEN_W'($urandom_range(0, 7));
		it.code_pattern = 6'($urandom_range(0, 63));
		send_item(it);
	endtask

	task automatic load_entry(input logic [7:0] c, input int len, input int pat);
		in_item_t it;
		it.mode         = MODE_TABLE;
		it.in_char      = c;
		it.code_length  = LEN_W'(len);
		it.code_pattern = 6'(pat);
		send_item(it);
		code_len_pool = {code_len_pool, ((len > MAX_SYMBOLS) ? MAX_SYMBOLS : len)};
		code_pat_pool = {code_pat_pool, pat};
		letter_pool   = {letter_pool, c};
	endtask

	task automatic random_entry();
		logic [7:0] c;
		c = ($urandom_range(0, 9) < 7) ? rand_letter() : 8'($urandom_range(0, 255));
		load_entry(c, $urandom_range(0, 7), $urandom_range(0, 63));
	endtask

	// Direction write once the block has drained
	task automatic set_direction(input logic d);
		in_valid <= 1'b0;
		@(negedge clk);
		while (chars_due != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
		cfg_wdata <= d;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic encode_step();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 15)
			random_entry();
		else if (roll < 75)
			send_char((letter_pool.size() > 0 && $urandom_range(0, 9) < 7) ?
				letter_pool[$urandom_range(0, letter_pool.size() - 1)] : rand_letter());
		else
			send_char(8'($urandom_range(0, 255)));
	endtask

	task automatic decode_step();
		int roll;
		int pick;
		int n;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			random_entry();
		end else if (roll < 70 && code_len_pool.size() > 0) begin
			// well-formed: symbols of a loaded code, then a terminator
			pick = $urandom_range(0, code_len_pool.size() - 1);
			for (int i = 0; i < code_len_pool[pick]; i++)
				send_char(((code_pat_pool[pick] >> i) & 1) ? CHAR_DASH : CHAR_DOT);
			send_char(rand_terminator());
		end else if (roll < 85) begin
			// random symbol run, sometimes past the code limit
			n = $urandom_range(1, 8);
			repeat (n)
				send_char($urandom_range(0, 1) ? CHAR_DASH : CHAR_DOT);
			send_char(rand_terminator());
		end else begin
			send_char(8'($urandom_range(0, 255)));
		end
	endtask

	// Output side backpressure
	initial begin
		int stall;
		int run;
		forever begin
			@(negedge clk);
			stall = idle_cycles();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			run = $urandom_range(1, 8);
			repeat (run) @(negedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		int phase_start;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Encode after reset: empty table, then loaded entries and letter bounds
		send_char("A");
		load_entry("A", 2, 6'h3E);          // bits above the length ignored
		load_entry("Z", 7, 6'h3F);          // over-long length saturates
		load_entry("a", 0, 6'h2A);          // zero-length code
		load_entry(8'hFF, 6, 6'h15);        // non-letter entry
		send_char("A");
		send_char("Z");
		send_char("a");
		send_char(8'hFF);
		send_char(8'h00);
		send_char("z");                     // letter not in table
		send_char("@");
		send_char("{");

		// Decode: table write inside a pending code, pass-through, overflow
		set_direction(DIR_DECODE);
		send_char(CHAR_DOT);
		send_char(CHAR_DASH);
		load_entry("E", 1, 0);
		send_char(" ");
		send_char(" ");
		repeat (7)
			send_char(CHAR_DASH);
		send_char("q");

		// Pending code survives a trip through the encode direction
		send_char(CHAR_DASH);
		set_direction(DIR_ENCODE);
		send_char("E");
		set_direction(DIR_DECODE);
		send_char("!");

		// Random part: a table burst, then alternating direction phases
		repeat (16)
			random_entry();
		for (int phase = 0; phase < 8; phase++) begin
			set_direction((phase % 2) ? DIR_ENCODE : DIR_DECODE);
			steady = (phase == 2 || phase == 5);
			phase_start = items_sent;
			while (items_sent - phase_start < 30) begin
				if (phase % 2)
					encode_step();
				else
					decode_step();
			end
		end
		steady = 1'b0;

		// Drain and report
		in_valid <= 1'b0;
		@(negedge clk);
		while (chars_due != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
